>>> design/pbs_pkg.sv
// ----------------------------------------------------------------------------
// Power button sequencer package
// Shared types and constants for the power button sequencer.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int unsigned NOW_W    = 64;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned SEQ_W    = 9;

  localparam logic [SEQ_W-1:0] SEQ_IDLE        = 9'd0;
  localparam logic [SEQ_W-1:0] SEQ_FADE_START  = 9'd1;
  localparam logic [SEQ_W-1:0] SEQ_FIRST_LIGHT = 9'd2;
  localparam logic [SEQ_W-1:0] SEQ_OFF_AT      = 9'd260;
  localparam logic [SEQ_W-1:0] SEQ_ON_START    = 9'd261;
  localparam logic [SEQ_W-1:0] SEQ_LIGHT_AT    = 9'd280;
  localparam logic [SEQ_W-1:0] SEQ_END_AT      = 9'd300;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FADE_NONE    = 2'd0,
    FADE_DARK    = 2'd1,
    FADE_RESTORE = 2'd2
  } fade_t;

endpackage

>>> design/pbs_if.sv
// ----------------------------------------------------------------------------
// Power button sequencer channels
// Valid/ready channels for service pass items and result items.
// ----------------------------------------------------------------------------
interface pbs_in_if import pbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             button_pressed;
  logic             power_on;
  logic [NOW_W-1:0] now_time;

  modport source (output valid, button_pressed, power_on, now_time, input ready);
  modport sink   (input valid, button_pressed, power_on, now_time, output ready);
endinterface

interface pbs_out_if ();
  logic       valid;
  logic       ready;
  logic       led_on;
  logic       power_enable;
  logic       power_disable;
  logic [1:0] fade_request;
  logic       activity;
  logic       busy_res;

  modport source (output valid, led_on, power_enable, power_disable, fade_request,
                  activity, busy_res, input ready);
  modport sink   (input valid, led_on, power_enable, power_disable, fade_request,
                  activity, busy_res, output ready);
endinterface

>>> design/power_button_sequencer.sv
// ----------------------------------------------------------------------------
// Power button sequencer
// Push-button LED control with timed power-on and fade-to-dark sequences.
// Each result item is registered and is offered in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the result register frees as it is taken.
// Reset (rst_n low, synchronous) clears button, LED, counter and change time,
// loads the short press window with 1000 and empties the result register.
// ----------------------------------------------------------------------------
module power_button_sequencer import pbs_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [WINDOW_W-1:0] cfg_wdata,
  pbs_in_if.sink              in_ch,
  pbs_out_if.source           out_ch
);

  logic [WINDOW_W-1:0]   window_r;
  logic                  btn_r, btn_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic                  led_r, led_nxt;

  logic                  out_valid_r;
  logic                  en_r, en_nxt;
  logic                  dis_r, dis_nxt;
  fade_t                 fade_r, fade_nxt;
  logic                  act_r, act_nxt;

  logic                  accept;
  logic                  change;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [SEQ_W-1:0]      seq_adv;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign now_t       = in_ch.now_time[TIME_WIDTH-1:0];
  assign elapsed     = now_t - last_r;
  assign change      = in_ch.button_pressed != btn_r;

  always_comb begin
    seq_nxt  = seq_r;
    led_nxt  = led_r;
    btn_nxt  = btn_r;
    last_nxt = last_r;
    en_nxt   = 1'b0;
    dis_nxt  = 1'b0;
    fade_nxt = FADE_NONE;
    act_nxt  = 1'b0;
    seq_adv  = seq_r + 9'd1;

    // advance a running sequence
    if (seq_r != SEQ_IDLE) begin
      seq_nxt = seq_adv;
      if (seq_adv == SEQ_OFF_AT) begin
        led_nxt = 1'b0;
        dis_nxt = 1'b1;
        seq_nxt = SEQ_IDLE;
      end else if (seq_adv == SEQ_END_AT) begin
        led_nxt = 1'b0;
        seq_nxt = SEQ_IDLE;
      end else if (seq_adv == SEQ_FIRST_LIGHT || seq_adv == SEQ_LIGHT_AT) begin
        led_nxt = 1'b1;
      end
    end

    if (change) begin
      btn_nxt  = in_ch.button_pressed;
      last_nxt = now_t;
      act_nxt  = 1'b1;
      led_nxt  = in_ch.button_pressed && (seq_nxt == SEQ_IDLE);
      if (seq_nxt == SEQ_IDLE) begin
        if (!in_ch.power_on) begin
          if (in_ch.button_pressed) begin
            en_nxt   = 1'b1;
            seq_nxt  = SEQ_ON_START;
            fade_nxt = FADE_RESTORE;
          end
        end else if (!in_ch.button_pressed &&
                     elapsed < TIME_WIDTH'(window_r)) begin
          seq_nxt  = SEQ_FADE_START;
          fade_nxt = FADE_DARK;
          led_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RESET;
      btn_r       <= 1'b0;
      last_r      <= '0;
      seq_r       <= SEQ_IDLE;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (accept) begin
        btn_r  <= btn_nxt;
        last_r <= last_nxt;
        seq_r  <= seq_nxt;
        led_r  <= led_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      en_r   <= en_nxt;
      dis_r  <= dis_nxt;
      fade_r <= fade_nxt;
      act_r  <= act_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.led_on        = led_r;
  assign out_ch.power_enable  = en_r;
  assign out_ch.power_disable = dis_r;
  assign out_ch.fade_request  = fade_r;
  assign out_ch.activity      = act_r;
  assign out_ch.busy_res      = seq_r != SEQ_IDLE;

endmodule

>>> design/pbs_checker.sv
// ----------------------------------------------------------------------------
// Power button sequencer checker
// Port-level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
module pbs_checker import pbs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       led_on,
  input logic       power_enable,
  input logic       power_disable,
  input logic [1:0] fade_request,
  input logic       activity,
  input logic       busy_res
);

  a_enable_with_restore: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> power_enable == (fade_request == FADE_RESTORE))
    else $error("power enable and restore request out of step");

  a_enable_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && power_enable |-> busy_res && activity && led_on)
    else $error("power enable without restore sequence");

  a_fade_dark_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fade_request == FADE_DARK |-> led_on && busy_res && activity)
    else $error("fade to dark without lit LED and running sequence");

  a_disable_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && power_disable && !activity |->
      !led_on && !busy_res && fade_request == FADE_NONE)
    else $error("power disable with LED lit, sequence running or fade requested");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

endmodule

bind power_button_sequencer pbs_checker u_pbs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .led_on        (out_ch.led_on),
  .power_enable  (out_ch.power_enable),
  .power_disable (out_ch.power_disable),
  .fade_request  (out_ch.fade_request),
  .activity      (out_ch.activity),
  .busy_res      (out_ch.busy_res)
);
